@@ hdl/mapped_histogram_dithered_binning_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the mapped histogram block
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef MAPPED_HISTOGRAM_DITHERED_BINNING_DEFINES_SVH
`define MAPPED_HISTOGRAM_DITHERED_BINNING_DEFINES_SVH

// The property must hold on every active clock edge.
`define MHDB_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define MHDB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MHDB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/mhdb_pkg.sv @@
// ----------------------------------------------------------------------------
// mhdb_pkg
// Types and constants shared by the mapped histogram front end, queue and
// back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mhdb_pkg;

	localparam int NUM_W  = 61;
	localparam int DEN_W  = 48;
	localparam int RN_W   = 45;
	localparam int DIV_W  = 64;
	localparam int STEP_W = 7;

	localparam logic [2:0] REG_SOURCE_LOW  = 3'd0;
	localparam logic [2:0] REG_SOURCE_HIGH = 3'd1;
	localparam logic [2:0] REG_SCALE_BITS  = 3'd2;
	localparam logic [2:0] REG_WINDOW_LOW  = 3'd3;
	localparam logic [2:0] REG_WINDOW_HIGH = 3'd4;
	localparam logic [2:0] REG_BIN_COUNT   = 3'd5;

	localparam logic [1:0] OP_INC   = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	typedef struct packed {
		logic [31:0] source_low;
		logic [31:0] source_high;
		logic [4:0]  source_scale_bits;
		logic [31:0] window_low;
		logic [31:0] window_high;
		logic [12:0] bin_count;
	} cfg_t;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_INC,
		CMD_READ,
		CMD_CLEAR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [11:0]      sel;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
		logic [RN_W-1:0]  rn;
		logic             multi;
		logic [31:0]      u;
	} cmd_t;

	typedef struct packed {
		logic [DIV_W-1:0]  rem0;
		logic [DIV_W-1:0]  bits;
		logic [DIV_W-1:0]  divisor;
		logic [STEP_W-1:0] steps;
	} div_req_t;

endpackage

`default_nettype wire

@@ hdl/mhdb_front.sv @@
// ----------------------------------------------------------------------------
// mhdb_front
// Accepts items, maps raw channels into the window and classifies each item
// into a back-end command over three pipeline stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mhdb_front import mhdb_pkg::*; #(
	parameter int MAX_BINS    = 4096,
	parameter int DITHER_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   enable,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             op,
	input  logic [15:0]            raw_value,
	input  logic                   raw_valid,
	input  logic [DITHER_BITS-1:0] dither,
	input  logic [11:0]            bin_select,
	output logic                   cmd_valid,
	input  logic                   cmd_ready,
	output cmd_t                   cmd
);

	logic advance;
	logic v_s1, v_s2, v_s3;

	logic [4:0]         scale_c;
	logic signed [32:0] range_c;
	logic signed [48:0] rxr_c;
	logic [31:0]        u_c;

	logic [1:0]         op_s1;
	logic [11:0]        sel_s1;
	logic [31:0]        u_s1;
	logic               rvalid_s1;
	logic signed [32:0] range_s1;
	logic signed [48:0] rxr_s1;

	logic signed [47:0] slow_c, lowe_c, highe_c;
	logic signed [49:0] coord_c, lowe50_c, highe50_c, diff_c;
	logic signed [32:0] width_c;
	logic               inwin_c;
	logic [DEN_W-1:0]   den_c;
	logic signed [45:0] rn_c;

	logic [1:0]         op_s2;
	logic [11:0]        sel_s2;
	logic [31:0]        u_s2;
	logic               inwin_s2;
	logic [DEN_W-1:0]   den_s2;
	logic [47:0]        diff_s2;
	logic signed [45:0] rn_s2;

	cmd_kind_t          kind_c;
	cmd_t               cmd_s3;

	assign advance  = !v_s3 || cmd_ready;
	assign in_ready = advance && enable;

	// Stage 1: raw channel times source range.
	assign scale_c = (cfg.source_scale_bits > 5'd16) ? 5'd16 : cfg.source_scale_bits;
	assign range_c = $signed({cfg.source_high[31], cfg.source_high})
		- $signed({cfg.source_low[31], cfg.source_low});
	assign rxr_c   = $signed({1'b0, raw_value}) * range_c;
	assign u_c     = 32'(dither) << (32 - DITHER_BITS);

	// Stage 2: coordinate and window edges, all scaled by 2^scale.
	assign slow_c    = $signed({{16{cfg.source_low[31]}}, cfg.source_low}) <<< scale_c;
	assign lowe_c    = $signed({{16{cfg.window_low[31]}}, cfg.window_low}) <<< scale_c;
	assign highe_c   = $signed({{16{cfg.window_high[31]}}, cfg.window_high}) <<< scale_c;
	assign coord_c   = $signed({{2{slow_c[47]}}, slow_c}) + $signed({rxr_s1[48], rxr_s1});
	assign lowe50_c  = $signed({{2{lowe_c[47]}}, lowe_c});
	assign highe50_c = $signed({{2{highe_c[47]}}, highe_c});
	assign width_c   = $signed({cfg.window_high[31], cfg.window_high})
		- $signed({cfg.window_low[31], cfg.window_low});
	assign inwin_c   = rvalid_s1 && (coord_c >= lowe50_c) && (coord_c <= highe50_c)
		&& !width_c[32] && (width_c != 33'sd0);
	assign den_c     = DEN_W'(width_c[31:0]) << scale_c;
	assign diff_c    = coord_c - lowe50_c;
	assign rn_c      = range_s1 * $signed({1'b0, cfg.bin_count});

	always_comb begin
		case (op_s2)
			OP_INC:   kind_c = inwin_s2 ? CMD_INC : CMD_NONE;
			OP_READ:  kind_c = (32'(sel_s2) < MAX_BINS) ? CMD_READ : CMD_NONE;
			OP_CLEAR: kind_c = (32'(sel_s2) < MAX_BINS) ? CMD_CLEAR : CMD_NONE;
			default:  kind_c = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid && in_ready;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			op_s1     <= op;
			sel_s1    <= bin_select;
			u_s1      <= u_c;
			rvalid_s1 <= raw_valid;
			range_s1  <= range_c;
			rxr_s1    <= rxr_c;

			op_s2     <= op_s1;
			sel_s2    <= sel_s1;
			u_s2      <= u_s1;
			inwin_s2  <= inwin_c;
			den_s2    <= den_c;
			diff_s2   <= diff_c[47:0];
			rn_s2     <= rn_c;

			cmd_s3.kind  <= kind_c;
			cmd_s3.sel   <= sel_s2;
			cmd_s3.num   <= diff_s2 * cfg.bin_count;
			cmd_s3.den   <= den_s2;
			cmd_s3.rn    <= rn_s2[RN_W-1:0];
			cmd_s3.multi <= rn_s2 > $signed({1'b0, den_s2});
			cmd_s3.u     <= u_s2;
		end
	end

	assign cmd_valid = v_s3;
	assign cmd       = cmd_s3;

endmodule

`default_nettype wire

@@ hdl/mhdb_fifo.sv @@
// ----------------------------------------------------------------------------
// mhdb_fifo
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "mapped_histogram_dithered_binning_defines.svh"

module mhdb_fifo import mhdb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cmd_t in_cmd,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t out_cmd
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push, pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= in_cmd;
	end

	`MHDB_ASSERT(a_fifo_bound, clk, arst_n, count_q != 2'd3, "queue count overflow")
	`MHDB_ASSERT_NXT(a_fifo_fill, clk, arst_n, push && !pop, count_q == $past(count_q) + 2'd1, "queue count did not grow")
	`MHDB_ASSERT_IMP(a_fifo_full_block, clk, arst_n, count_q == 2'd2, !in_ready, "full queue took a transfer")

endmodule

`default_nettype wire

@@ hdl/mhdb_div.sv @@
// ----------------------------------------------------------------------------
// mhdb_div
// Shared radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "mapped_histogram_dithered_binning_defines.svh"

module mhdb_div import mhdb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  div_req_t         req,
	output logic             done,
	output logic [DIV_W-1:0] quo
);

	logic [DIV_W-1:0]  rem_q, bits_q, div_q, quo_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q, done_q;
	logic [DIV_W-1:0]  shifted;
	logic              ge;

	// The caller starts with a partial remainder below the divisor, so the
	// shifted remainder never loses its top bit.
	assign shifted = {rem_q[DIV_W-2:0], bits_q[DIV_W-1]};
	assign ge      = (shifted >= div_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == STEP_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= req.rem0;
			bits_q <= req.bits;
			div_q  <= req.divisor;
			quo_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? (shifted - div_q) : shifted;
			bits_q <= bits_q << 1;
			quo_q  <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

	`MHDB_ASSERT_IMP(a_div_start_idle, clk, arst_n, start, !busy_q, "divider restarted while busy")
	`MHDB_ASSERT_IMP(a_div_done_idle, clk, arst_n, done, !busy_q, "divider done while busy")
	`MHDB_ASSERT_NXT(a_div_done_pulse, clk, arst_n, done, !done, "divider done held too long")

endmodule

`default_nettype wire

@@ hdl/mhdb_back.sv @@
// ----------------------------------------------------------------------------
// mhdb_back
// Resolves the dithered bin with the shared divider, performs the counter
// read-modify-write and holds the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "mapped_histogram_dithered_binning_defines.svh"

module mhdb_back import mhdb_pkg::*; #(
	parameter int MAX_BINS   = 4096,
	parameter int COUNT_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	output logic        ready_for_items,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_t        cmd,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] bin_index,
	output logic [31:0] count_value,
	output logic        hit
);

	localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int BW = 46;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_QF,
		ST_RQ,
		ST_P,
		ST_STEP,
		ST_I,
		ST_BIN,
		ST_READ,
		ST_UPDATE,
		ST_NULL
	} state_t;

	state_t             state_q;
	cmd_t               cmd_q;
	logic [12:0]        q_q;
	logic [15:0]        f_q;
	logic [60:0]        rq_q;
	logic [BW-1:0]      hi_q;
	logic [32:0]        p_q;
	logic [BW-1:0]      bin_q;
	logic [AW-1:0]      addr_q, clr_q;
	logic               start_q;
	div_req_t           req_q;
	logic               out_valid_q, hit_q;
	logic [11:0]        bin_index_q;
	logic [31:0]        count_q;

	logic               div_done;
	logic [DIV_W-1:0]   div_quo;

	logic [COUNT_BITS-1:0] mem [MAX_BINS];
	logic [COUNT_BITS-1:0] rdata_q, upd_c;
	logic                  wr_en, rd_en;
	logic [AW-1:0]         wr_addr;
	logic [COUNT_BITS-1:0] wr_data;

	logic          pop, out_free, out_loading;
	logic [12:0]   q_nx;
	logic [15:0]   f_nx;
	logic [16:0]   t_c;
	logic          up_c;
	logic [61:0]   sum_c;
	logic [32:0]   st_c;
	logic [33:0]   d_c;
	logic [33:0]   i_c;

	mhdb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.req    (req_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign cmd_ready       = (state_q == ST_IDLE);
	assign ready_for_items = (state_q != ST_CLEAR);
	assign pop             = cmd_valid && cmd_ready;
	assign out_free        = !out_valid_q || out_ready;
	assign out_loading     = (state_q == ST_UPDATE) || (state_q == ST_NULL);

	assign q_nx  = div_quo[28:16];
	assign f_nx  = div_quo[15:0];
	assign t_c   = 17'h10000 - {1'b0, f_q};
	// Two-bin case: step up when the dither reaches the remaining fraction.
	assign up_c  = (f_nx != 16'd0) && ({17'h10000 - {1'b0, f_nx}, 16'b0} <= {1'b0, cmd_q.u});
	assign sum_c = {33'b0, q_q, 16'b0} + 62'(f_q) + 62'(div_quo[60:0]);
	assign st_c  = div_quo[32:0];
	assign d_c   = 34'(cmd_q.u) - 34'(p_q) + 34'(st_c) - 34'd1;
	assign i_c   = div_quo[33:0];
	assign upd_c = (cmd_q.kind == CMD_CLEAR) ? '0
		: (cmd_q.kind == CMD_INC) ? rdata_q + 1'b1 : rdata_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_q;
		wr_data = upd_c;
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else if (state_q == ST_UPDATE && out_free && cmd_q.kind != CMD_READ) begin
			wr_en = 1'b1;
		end
	end

	assign rd_en = (state_q == ST_READ);

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rdata_q <= mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			bin_index_q <= '0;
			count_q     <= '0;
			cmd_q       <= '0;
			req_q       <= '0;
			addr_q      <= '0;
			q_q         <= '0;
			f_q         <= '0;
			rq_q        <= '0;
			hi_q        <= '0;
			p_q         <= '0;
			bin_q       <= '0;
		end else begin
			start_q <= 1'b0;
			if (out_valid_q && out_ready && !out_loading) out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(MAX_BINS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (pop) begin
						cmd_q <= cmd;
						case (cmd.kind)
							CMD_INC: begin
								start_q       <= 1'b1;
								req_q.rem0    <= DIV_W'(cmd.num >> 13);
								req_q.bits    <= {cmd.num[12:0], 51'b0};
								req_q.divisor <= DIV_W'(cmd.den);
								req_q.steps   <= STEP_W'(29);
								state_q       <= ST_QF;
							end
							CMD_READ, CMD_CLEAR: begin
								addr_q  <= AW'(cmd.sel);
								state_q <= ST_READ;
							end
							default: state_q <= ST_NULL;
						endcase
					end
				end
				ST_QF: begin
					if (div_done) begin
						q_q <= q_nx;
						f_q <= f_nx;
						if (!cmd_q.multi) begin
							bin_q   <= BW'(q_nx) + BW'(up_c);
							state_q <= ST_BIN;
						end else begin
							start_q       <= 1'b1;
							req_q.rem0    <= '0;
							req_q.bits    <= {cmd_q.rn, 19'b0};
							req_q.divisor <= DIV_W'(cmd_q.den);
							req_q.steps   <= STEP_W'(61);
							state_q       <= ST_RQ;
						end
					end
				end
				ST_RQ: begin
					if (div_done) begin
						rq_q          <= div_quo[60:0];
						hi_q          <= sum_c[61:16];
						start_q       <= 1'b1;
						req_q.rem0    <= DIV_W'(t_c[16:1]);
						req_q.bits    <= {t_c[0], 63'b0};
						req_q.divisor <= DIV_W'(div_quo[60:0]);
						req_q.steps   <= STEP_W'(33);
						state_q       <= ST_P;
					end
				end
				ST_P: begin
					if (div_done) begin
						p_q <= div_quo[32:0];
						if (div_quo[32:0] >= 33'(cmd_q.u)) begin
							bin_q   <= BW'(q_q);
							state_q <= ST_BIN;
						end else begin
							start_q       <= 1'b1;
							req_q.rem0    <= DIV_W'(17'h08000);
							req_q.bits    <= '0;
							req_q.divisor <= DIV_W'(rq_q);
							req_q.steps   <= STEP_W'(33);
							state_q       <= ST_STEP;
						end
					end
				end
				ST_STEP: begin
					if (div_done) begin
						if (st_c == 33'd0) begin
							bin_q   <= hi_q;
							state_q <= ST_BIN;
						end else begin
							// Ceiling of the dither excess over one bin's share.
							start_q       <= 1'b1;
							req_q.rem0    <= '0;
							req_q.bits    <= {d_c, 30'b0};
							req_q.divisor <= DIV_W'(st_c);
							req_q.steps   <= STEP_W'(34);
							state_q       <= ST_I;
						end
					end
				end
				ST_I: begin
					if (div_done) begin
						bin_q   <= (BW'(i_c) < (hi_q - BW'(q_q))) ? BW'(q_q) + BW'(i_c) : hi_q;
						state_q <= ST_BIN;
					end
				end
				ST_BIN: begin
					if (bin_q >= BW'(cfg.bin_count) || bin_q >= BW'(MAX_BINS)) begin
						state_q <= ST_NULL;
					end else begin
						addr_q  <= bin_q[AW-1:0];
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_UPDATE;
				ST_UPDATE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						hit_q       <= 1'b1;
						bin_index_q <= 12'(addr_q);
						count_q     <= 32'(upd_c);
						state_q     <= ST_IDLE;
					end
				end
				ST_NULL: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						hit_q       <= 1'b0;
						bin_index_q <= '0;
						count_q     <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign bin_index   = bin_index_q;
	assign count_value = count_q;
	assign hit         = hit_q;

	`MHDB_ASSERT_IMP(a_back_rd_range, clk, arst_n, rd_en, 32'(addr_q) < MAX_BINS, "counter read out of range")
	`MHDB_ASSERT_IMP(a_back_no_pop_clear, clk, arst_n, state_q == ST_CLEAR, !cmd_ready, "command taken during clear pass")
	`MHDB_ASSERT_NXT(a_back_pop_leaves, clk, arst_n, pop, state_q != ST_IDLE, "command taken but not started")

endmodule

`default_nettype wire

@@ hdl/mapped_histogram_dithered_binning.sv @@
// ----------------------------------------------------------------------------
// mapped_histogram_dithered_binning: mapped 1-D histogram with random dither
// Path: 3 front stages, a two-entry queue, then the read and update states for read or clear.
// The back end holds one item at a time; a read or clear passes through its read and
// update states, and an increment first runs the shared one-bit-per-cycle divider
// (29 steps; for wide bins up to 61, 33, 33 and 34 steps more).
// Reset runs a clearing pass over all MAX_BINS counters; no item is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mapped_histogram_dithered_binning import mhdb_pkg::*; #(
	parameter int MAX_BINS    = 4096,
	parameter int COUNT_BITS  = 32,
	parameter int DITHER_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [2:0]             cfg_index,
	input  logic [31:0]            cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             op,
	input  logic [15:0]            raw_value,
	input  logic                   raw_valid,
	input  logic [DITHER_BITS-1:0] dither,
	input  logic [11:0]            bin_select,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [11:0]            bin_index,
	output logic [31:0]            count_value,
	output logic                   hit
);

	cfg_t cfg_q;
	logic back_ready;
	logic cmd_valid_f, cmd_ready_f, cmd_valid_b, cmd_ready_b;
	cmd_t cmd_f, cmd_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_low        <= 32'd0;
			cfg_q.source_high       <= 32'd67108864;
			cfg_q.source_scale_bits <= 5'd10;
			cfg_q.window_low        <= 32'd0;
			cfg_q.window_high       <= 32'd67108864;
			cfg_q.bin_count         <= 13'd4096;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SOURCE_LOW:  cfg_q.source_low        <= cfg_data;
				REG_SOURCE_HIGH: cfg_q.source_high       <= cfg_data;
				REG_SCALE_BITS:  cfg_q.source_scale_bits <= cfg_data[4:0];
				REG_WINDOW_LOW:  cfg_q.window_low        <= cfg_data;
				REG_WINDOW_HIGH: cfg_q.window_high       <= cfg_data;
				REG_BIN_COUNT:   cfg_q.bin_count         <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	mhdb_front #(
		.MAX_BINS    (MAX_BINS),
		.DITHER_BITS (DITHER_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.enable     (back_ready),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.raw_value  (raw_value),
		.raw_valid  (raw_valid),
		.dither     (dither),
		.bin_select (bin_select),
		.cmd_valid  (cmd_valid_f),
		.cmd_ready  (cmd_ready_f),
		.cmd        (cmd_f)
	);

	mhdb_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd_valid_f),
		.in_ready  (cmd_ready_f),
		.in_cmd    (cmd_f),
		.out_valid (cmd_valid_b),
		.out_ready (cmd_ready_b),
		.out_cmd   (cmd_b)
	);

	mhdb_back #(
		.MAX_BINS   (MAX_BINS),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.ready_for_items (back_ready),
		.cmd_valid       (cmd_valid_b),
		.cmd_ready       (cmd_ready_b),
		.cmd             (cmd_b),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.bin_index       (bin_index),
		.count_value     (count_value),
		.hit             (hit)
	);

endmodule

`default_nettype wire
